/* design/mld_pkg.sv */
// ----------------------------------------------------------------------------
// Morse light decoder package
// Shared types, register codes, reset values and the character ROM.
// ----------------------------------------------------------------------------
package mld_pkg;

  localparam int unsigned SampleWidth  = 12;
  localparam int unsigned MaxElements  = 6;
  localparam int unsigned ElemCntWidth = 3;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [11:0] ThresholdReset = 12'd2815;
  localparam logic [7:0]  DashMinReset   = 8'd3;
  localparam logic [7:0]  DecodeGapReset = 8'd4;
  localparam logic [7:0]  MinDecodeGap   = 8'd2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgLightThreshold = 2'd0,
    CfgDashMinSamples = 2'd1,
    CfgDecodeGap      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvDot      = 3'd1,
    EvDash     = 3'd2,
    EvWait     = 3'd3,
    EvDecoded  = 3'd4,
    EvEnd      = 3'd5,
    EvOverflow = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    LedOff  = 2'd0,
    LedRed  = 2'd1,
    LedBlue = 2'd2
  } led_e;

  typedef struct packed {
    logic [7:0] dash_min;
    logic [7:0] decode_gap;
  } cfg_t;

  typedef struct packed {
    event_e     event_res;
    led_e       led_state;
    logic       char_valid;
    logic [7:0] char_code;
  } result_t;

  // Index is the element count (1 to 6) and the element bits, dash as one.
  function automatic logic [7:0] char_lookup(input logic [ElemCntWidth-1:0] len,
                                             input logic [MaxElements-1:0] bits);
    logic [7:0] code;
    code = 8'h00;
    case ({len, bits})
      {3'd1, 6'd0}:  code = "E";
      {3'd1, 6'd1}:  code = "T";
      {3'd2, 6'd0}:  code = "I";
      {3'd2, 6'd1}:  code = "N";
      {3'd2, 6'd2}:  code = "A";
      {3'd2, 6'd3}:  code = "M";
      {3'd3, 6'd0}:  code = "S";
      {3'd3, 6'd1}:  code = "D";
      {3'd3, 6'd2}:  code = "R";
      {3'd3, 6'd3}:  code = "G";
      {3'd3, 6'd4}:  code = "U";
      {3'd3, 6'd5}:  code = "K";
      {3'd3, 6'd6}:  code = "W";
      {3'd3, 6'd7}:  code = "O";
      {3'd4, 6'd0}:  code = "H";
      {3'd4, 6'd1}:  code = "B";
      {3'd4, 6'd2}:  code = "L";
      {3'd4, 6'd3}:  code = "Z";
      {3'd4, 6'd4}:  code = "F";
      {3'd4, 6'd5}:  code = "C";
      {3'd4, 6'd6}:  code = "P";
      {3'd4, 6'd7}:  code = "%";
      {3'd4, 6'd8}:  code = "V";
      {3'd4, 6'd9}:  code = "X";
      {3'd4, 6'd10}: code = 8'h5c;
      {3'd4, 6'd11}: code = "Q";
      {3'd4, 6'd12}: code = "#";
      {3'd4, 6'd13}: code = "Y";
      {3'd4, 6'd14}: code = "J";
      {3'd4, 6'd15}: code = "^";
      {3'd5, 6'd0}:  code = "5";
      {3'd5, 6'd1}:  code = "6";
      {3'd5, 6'd3}:  code = "7";
      {3'd5, 6'd7}:  code = "8";
      {3'd5, 6'd9}:  code = "/";
      {3'd5, 6'd10}: code = "+";
      {3'd5, 6'd13}: code = "(";
      {3'd5, 6'd15}: code = "9";
      {3'd5, 6'd16}: code = "4";
      {3'd5, 6'd17}: code = "=";
      {3'd5, 6'd24}: code = "3";
      {3'd5, 6'd28}: code = "2";
      {3'd5, 6'd30}: code = "1";
      {3'd5, 6'd31}: code = "0";
      {3'd6, 6'd7}:  code = ":";
      {3'd6, 6'd12}: code = 8'h3f;
      {3'd6, 6'd18}: code = 8'h22;
      {3'd6, 6'd21}: code = ";";
      {3'd6, 6'd22}: code = "@";
      {3'd6, 6'd30}: code = 8'h27;
      {3'd6, 6'd33}: code = "-";
      {3'd6, 6'd42}: code = ".";
      {3'd6, 6'd44}: code = "_";
      {3'd6, 6'd45}: code = ")";
      {3'd6, 6'd51}: code = ",";
      {3'd6, 6'd53}: code = "!";
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* design/morse_light_decoder.sv */
// ----------------------------------------------------------------------------
// Morse light decoder
// Turns light sensor samples into Morse elements, decode events and characters.
//
//   Channel   Direction  Handshake           Payload
//   input     in         push / full         sample_i
//   result    out        pop / empty         event_res_o, led_state_o,
//                                            char_valid_o, char_code_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One sample is taken per cycle unless the classification queue is full, and
// gives one result: it is classified on entry, queued, made into a result by
// the back end and written to the result queue, from which it is popped; the
// back end updates its run counters once per cycle while it is not stalled.
// Reset restores the register defaults and clears the counters and queues.
// A full result queue stalls the back end; input stalls when the
// two-entry classification queue is full.
// ----------------------------------------------------------------------------
module morse_light_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mld_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [mld_pkg::SampleWidth-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [mld_pkg::SampleWidth-1:0] sample_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      event_res_o,
  output logic [1:0]                      led_state_o,
  output logic                            char_valid_o,
  output logic [7:0]                      char_code_o
);

  mld_pkg::cfg_t    cfg;
  mld_pkg::result_t res_in;
  mld_pkg::result_t res_out;
  logic             cls_push;
  logic             cls_light_in;
  logic             cls_full;
  logic             cls_pop;
  logic             cls_light_out;
  logic             cls_empty;
  logic             res_push;
  logic             res_full;

  mld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .cls_push_o  (cls_push),
    .cls_light_o (cls_light_in),
    .cls_full_i  (cls_full),
    .cfg_o       (cfg)
  );

  mld_fifo #(
    .Width (1),
    .Depth (2)
  ) u_cls_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_push),
    .data_i  (cls_light_in),
    .full_o  (cls_full),
    .pop_i   (cls_pop),
    .data_o  (cls_light_out),
    .empty_o (cls_empty)
  );

  mld_back #(
    .CountWidth (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cls_empty_i (cls_empty),
    .cls_light_i (cls_light_out),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  mld_fifo #(
    .Width ($bits(mld_pkg::result_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign event_res_o  = res_out.event_res;
  assign led_state_o  = res_out.led_state;
  assign char_valid_o = res_out.char_valid;
  assign char_code_o  = res_out.char_code;

endmodule

/* design/mld_fifo.sv */
// ----------------------------------------------------------------------------
// Morse light decoder queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module mld_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/mld_front.sv */
// ----------------------------------------------------------------------------
// Morse light decoder front end
// Holds the configuration registers and classifies each sample as light or dark.
// ----------------------------------------------------------------------------
module mld_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mld_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [mld_pkg::SampleWidth-1:0]  cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [mld_pkg::SampleWidth-1:0]  sample_i,
  output logic                             cls_push_o,
  output logic                             cls_light_o,
  input  logic                             cls_full_i,
  output mld_pkg::cfg_t                    cfg_o
);

  logic [mld_pkg::SampleWidth-1:0] threshold_q, threshold_d;
  logic [7:0]                      dash_min_q, dash_min_d;
  logic [7:0]                      decode_gap_q, decode_gap_d;

  assign cfg_ready_o = 1'b1;
  assign full        = cls_full_i;
  assign cls_push_o  = push;
  assign cls_light_o = (sample_i >= threshold_q);
  assign cfg_o       = '{dash_min: dash_min_q, decode_gap: decode_gap_q};

  always_comb begin
    threshold_d  = threshold_q;
    dash_min_d   = dash_min_q;
    decode_gap_d = decode_gap_q;
    if (cfg_valid_i) begin
      unique case (mld_pkg::cfg_idx_e'(cfg_index_i))
        mld_pkg::CfgLightThreshold: threshold_d  = cfg_data_i;
        mld_pkg::CfgDashMinSamples: dash_min_d   = cfg_data_i[7:0];
        mld_pkg::CfgDecodeGap:      decode_gap_d = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= mld_pkg::ThresholdReset;
      dash_min_q   <= mld_pkg::DashMinReset;
      decode_gap_q <= mld_pkg::DecodeGapReset;
    end else begin
      threshold_q  <= threshold_d;
      dash_min_q   <= dash_min_d;
      decode_gap_q <= decode_gap_d;
    end
  end

endmodule

/* design/mld_back.sv */
// ----------------------------------------------------------------------------
// Morse light decoder back end
// Tracks light and dark runs, collects elements and decodes characters.
// ----------------------------------------------------------------------------
module mld_back #(
  parameter int unsigned CountWidth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mld_pkg::cfg_t    cfg_i,
  input  logic             cls_empty_i,
  input  logic             cls_light_i,
  output logic             cls_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output mld_pkg::result_t res_o
);

  logic [CountWidth-1:0]                light_q, light_d;
  logic [CountWidth-1:0]                dark_q, dark_d;
  logic [mld_pkg::ElemCntWidth-1:0]     count_q, count_d;
  logic [mld_pkg::MaxElements-1:0]      bits_q, bits_d;
  logic [CountWidth-1:0]                light_inc;
  logic [CountWidth-1:0]                dark_inc;
  logic [CountWidth-1:0]                dash_min;
  logic [CountWidth-1:0]                gap;
  logic                                 go;
  logic                                 is_dash;
  logic [7:0]                           rom_code;

  assign go         = !cls_empty_i && !res_full_i;
  assign cls_pop_o  = go;
  assign res_push_o = go;
  assign light_inc  = (light_q == '1) ? light_q : light_q + 1'b1;
  assign dark_inc   = (dark_q == '1) ? dark_q : dark_q + 1'b1;
  assign dash_min   = CountWidth'(cfg_i.dash_min);
  assign gap        = (cfg_i.decode_gap < mld_pkg::MinDecodeGap) ?
                      CountWidth'(mld_pkg::MinDecodeGap) : CountWidth'(cfg_i.decode_gap);
  assign is_dash    = (light_q >= dash_min);
  assign rom_code   = mld_pkg::char_lookup(count_q, bits_q);

  always_comb begin
    light_d   = light_q;
    dark_d    = dark_q;
    count_d   = count_q;
    bits_d    = bits_q;
    res_o     = '{event_res: mld_pkg::EvNone, led_state: mld_pkg::LedOff,
                  char_valid: 1'b0, char_code: 8'h00};
    if (cls_light_i) begin
      light_d         = light_inc;
      dark_d          = '0;
      res_o.led_state = (light_inc >= dash_min) ? mld_pkg::LedBlue : mld_pkg::LedRed;
    end else if (light_q != '0) begin
      light_d = '0;
      dark_d  = CountWidth'(1);
      if (count_q == mld_pkg::ElemCntWidth'(mld_pkg::MaxElements)) begin
        count_d         = '0;
        bits_d          = '0;
        res_o.event_res = mld_pkg::EvOverflow;
      end else begin
        bits_d          = bits_q | (mld_pkg::MaxElements'(is_dash) << count_q);
        count_d         = count_q + 1'b1;
        res_o.event_res = is_dash ? mld_pkg::EvDash : mld_pkg::EvDot;
      end
    end else begin
      dark_d = dark_inc;
      if (dark_inc < gap) begin
        res_o.event_res = mld_pkg::EvWait;
      end else if (dark_inc == gap) begin
        res_o.event_res = mld_pkg::EvDecoded;
        if (count_q != '0) begin
          res_o.char_valid = 1'b1;
          res_o.char_code  = rom_code;
        end
      end else begin
        res_o.event_res = mld_pkg::EvEnd;
        count_d         = '0;
        bits_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= '0;
      dark_q  <= '0;
      count_q <= '0;
      bits_q  <= '0;
    end else if (go) begin
      light_q <= light_d;
      dark_q  <= dark_d;
      count_q <= count_d;
      bits_q  <= bits_d;
    end
  end

endmodule
